@@ hw/rtl/spc_pkg.sv @@
package spc_pkg;

   // Fixed field widths of the item formats
   localparam int FUNC_BITS   = 3;
   localparam int VALUE_BITS  = 24;
   localparam int EVENT_BITS  = 3;
   localparam int RANGE_BITS  = 24;
   localparam int PERCFG_BITS = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   // Command codes
   localparam logic [FUNC_BITS-1:0] FUNC_TICK      = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_MOVE_REL  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_MOVE_ABS  = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_MOVE_ZERO = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_STEP      = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_STOP      = 3'd5;
   localparam logic [FUNC_BITS-1:0] FUNC_SET_POS   = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SHIFT     = 3'd7;

   // Event codes
   localparam logic [EVENT_BITS-1:0] EV_UPDATE  = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_STARTED = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_FINISH  = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_ABORT   = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_REFUSE  = 3'd4;
   localparam logic [EVENT_BITS-1:0] EV_ACK     = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_LOW   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_HIGH  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_DEF  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_FAST = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_SPEED  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT_DIR  = 3'd5;

   // Reset values of the registers
   localparam logic [RANGE_BITS-1:0]  RANGE_LOW_RST   = 24'h800000;
   localparam logic [RANGE_BITS-1:0]  RANGE_HIGH_RST  = 24'h7FFFFF;
   localparam logic [PERCFG_BITS-1:0] PERIOD_DEF_RST  = 16'd1000;
   localparam logic [PERCFG_BITS-1:0] PERIOD_FAST_RST = 16'd250;

   // One queued input's worth of results (one or two events)
   typedef struct packed {
      logic [EVENT_BITS-1:0] ev0;
      logic [EVENT_BITS-1:0] ev1;
      logic                  two;
      logic [VALUE_BITS-1:0] position;
      logic                  direction_pin;
      logic                  step_pulse;
      logic                  moving;
   } result_type;

endpackage

@@ hw/rtl/stepper_position_controller.sv @@
// Stepper position controller, whole-step units.
// req channel: one command item per handshake; req_tuser carries func, req_tdata the
//    signed value. Ticks (func 0) clock the per-step period timer.
// rsp channel: zero, one or two result items per command; rsp_tuser is the event code,
//    rsp_tlast marks the final result of a command. A quiet tick gives nothing.
// csr channel: register writes by index, always ready; user must write only while the block is idle, unenforced.
// Path: an accepted item goes into the input register; its results are then written
//    to the result queue and offered from the queue head.
// Throughput: one item per clock while rsp_tready is high and each item gives at most one
//    result; an item with two results holds the rsp side until both are taken. The 4-entry
//    result queue sets this: req_tready drops when queued plus in-flight items reach its depth.
// Stall: a stalled rsp side fills the queue, then req_tready falls; nothing is lost.
// Reset: position 0, nothing to go, direction positive, timer idle, queue empty,
//    registers back to their defaults.
module stepper_position_controller #(
   parameter int POSITION_BITS = 24,
   parameter int PERIOD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // command items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] value
   input  logic [2:0]  req_tuser,   // [2:0] func
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] position, [24] direction_pin,
                                    // [25] step_pulse, [26] moving, [31:27] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast,   // last result of this command
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int PB = POSITION_BITS;
   localparam int QB = PERIOD_BITS;
   // Compare/distance width: holds any position, value or their difference
   localparam int CW = ((PB > spc_pkg::VALUE_BITS) ? PB : spc_pkg::VALUE_BITS) + 2;
   localparam int DEPTH = 4;
   localparam int PTR_BITS = 2;

   // ---------------- configuration registers ----------------
   logic [spc_pkg::RANGE_BITS-1:0]  range_low_ff, range_high_ff;
   logic [spc_pkg::PERCFG_BITS-1:0] period_def_ff, period_fast_ff;
   logic                            fast_speed_ff, invert_dir_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= spc_pkg::RANGE_LOW_RST;
         range_high_ff  <= spc_pkg::RANGE_HIGH_RST;
         period_def_ff  <= spc_pkg::PERIOD_DEF_RST;
         period_fast_ff <= spc_pkg::PERIOD_FAST_RST;
         fast_speed_ff  <= 1'b0;
         invert_dir_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spc_pkg::CSR_RANGE_LOW:   range_low_ff   <= csr_data;
            spc_pkg::CSR_RANGE_HIGH:  range_high_ff  <= csr_data;
            spc_pkg::CSR_PERIOD_DEF:  period_def_ff  <= csr_data[15:0];
            spc_pkg::CSR_PERIOD_FAST: period_fast_ff <= csr_data[15:0];
            spc_pkg::CSR_FAST_SPEED:  fast_speed_ff  <= csr_data[0];
            spc_pkg::CSR_INVERT_DIR:  invert_dir_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                            in_valid_ff;
   logic [spc_pkg::FUNC_BITS-1:0]   func_ff;
   logic [spc_pkg::VALUE_BITS-1:0]  value_ff;
   logic [PTR_BITS:0]               count_ff;  // queued commands
   logic                            req_fire;

   // Room is reserved for the item in the input register too
   assign req_tready = ({1'b0, count_ff} + {{(PTR_BITS+1){1'b0}}, in_valid_ff}) <
                       (PTR_BITS + 2)'(DEPTH);
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
   end

   // ---------------- motion state ----------------
   logic [PB-1:0] position_ff, position_in;
   logic [PB-1:0] steps_ff, steps_in;
   logic          dir_ff, dir_in;       // 1 = positive
   logic          pulse_ff, pulse_in;
   logic [QB-1:0] count_per_ff, count_per_in;

   // Shared helpers
   logic signed [CW-1:0] lo_s, hi_s, val_s, pos_s, step_s, move_dist;
   logic [CW-1:0]        mag;
   logic [PB-1:0]        mag_sat, pos_step;
   logic                 val_ok, pos_ok, step_ok, moving_now, is_step_cmd;
   logic [spc_pkg::PERCFG_BITS-1:0] per_raw;
   logic [QB-1:0]        per_sel, per_eff;

   assign lo_s  = CW'($signed(range_low_ff));
   assign hi_s  = CW'($signed(range_high_ff));
   assign val_s = CW'($signed(value_ff));
   assign pos_s = CW'($signed(position_ff));
   assign pos_step = position_ff + (dir_ff ? PB'(1) : {PB{1'b1}});
   assign step_s = CW'($signed(pos_step));

   assign val_ok  = (val_s >= lo_s) && (val_s <= hi_s);
   assign pos_ok  = (pos_s >= lo_s) && (pos_s <= hi_s);
   assign step_ok = (step_s >= lo_s) && (step_s <= hi_s);
   assign moving_now = (steps_ff != '0) || pulse_ff;
   assign is_step_cmd = (func_ff == spc_pkg::FUNC_STEP);

   // Signed move distance per command kind
   always_comb begin
      priority case (func_ff)
         spc_pkg::FUNC_MOVE_ABS:  move_dist = val_s - pos_s;
         spc_pkg::FUNC_MOVE_ZERO: move_dist = -pos_s;
         default:                 move_dist = val_s;
      endcase
   end

   assign mag = move_dist[CW-1] ? $unsigned(-move_dist) : $unsigned(move_dist);
   // Saturate at the all-ones step count
   assign mag_sat = (|mag[CW-1:PB]) ? {PB{1'b1}} : mag[PB-1:0];

   // A zero period acts as one tick
   assign per_raw = fast_speed_ff ? period_fast_ff : period_def_ff;
   assign per_sel = QB'(per_raw);
   assign per_eff = (per_sel == '0) ? QB'(1) : per_sel;

   // ---------------- command evaluation ----------------
   logic [spc_pkg::EVENT_BITS-1:0] ev0, ev1;
   logic [1:0]                     nev;
   logic                           started;
   logic [PB-1:0]                  steps_dec;

   assign steps_dec = (steps_ff != '0) ? steps_ff - PB'(1) : '0;

   always_comb begin
      position_in  = position_ff;
      steps_in     = steps_ff;
      dir_in       = dir_ff;
      pulse_in     = pulse_ff;
      count_per_in = count_per_ff;
      ev0          = spc_pkg::EV_UPDATE;
      ev1          = spc_pkg::EV_UPDATE;
      nev          = 2'd0;
      started      = 1'b0;

      unique case (func_ff)
         spc_pkg::FUNC_TICK: begin
            if (pulse_ff) begin
               if (count_per_ff <= QB'(1)) begin
                  // pulse ends: take the step, then go on, abort or finish
                  pulse_in     = 1'b0;
                  count_per_in = '0;
                  position_in  = pos_step;
                  steps_in     = steps_dec;
                  ev0          = spc_pkg::EV_UPDATE;
                  if (steps_dec == '0) begin
                     ev1 = spc_pkg::EV_FINISH;
                     nev = 2'd2;
                  end else if (step_ok) begin
                     pulse_in     = 1'b1;
                     count_per_in = per_eff;
                     started      = 1'b1;
                     nev          = 2'd1;
                  end else begin
                     steps_in = '0;
                     ev1      = spc_pkg::EV_ABORT;
                     nev      = 2'd2;
                  end
               end else begin
                  count_per_in = count_per_ff - QB'(1);
               end
            end
         end
         spc_pkg::FUNC_MOVE_REL, spc_pkg::FUNC_MOVE_ABS,
         spc_pkg::FUNC_MOVE_ZERO, spc_pkg::FUNC_STEP: begin
            if (moving_now || ((func_ff == spc_pkg::FUNC_MOVE_ABS) && !val_ok)) begin
               ev0 = spc_pkg::EV_REFUSE;
               nev = 2'd1;
            end else begin
               ev0 = spc_pkg::EV_STARTED;
               if (is_step_cmd) begin
                  steps_in = PB'(1);     // single step keeps the direction
               end else begin
                  dir_in   = !move_dist[CW-1];
                  steps_in = mag_sat;
               end
               if (!is_step_cmd && (mag_sat == '0)) begin
                  ev1 = spc_pkg::EV_FINISH;
                  nev = 2'd2;
               end else if (pos_ok) begin
                  pulse_in     = 1'b1;
                  count_per_in = per_eff;
                  started      = 1'b1;
                  nev          = 2'd1;
               end else begin
                  steps_in = '0;
                  ev1      = spc_pkg::EV_ABORT;
                  nev      = 2'd2;
               end
            end
         end
         spc_pkg::FUNC_STOP: begin
            // pulse in flight still runs out
            steps_in = '0;
            ev0      = spc_pkg::EV_ACK;
            nev      = 2'd1;
         end
         spc_pkg::FUNC_SET_POS: begin
            nev = 2'd1;
            if (val_ok) begin
               position_in = PB'($signed(value_ff));
               ev0         = spc_pkg::EV_UPDATE;
            end else begin
               ev0 = spc_pkg::EV_REFUSE;
            end
         end
         spc_pkg::FUNC_SHIFT: begin
            nev = 2'd1;
            if (moving_now) begin
               ev0 = spc_pkg::EV_REFUSE;
            end else begin
               position_in = position_ff - PB'($signed(value_ff));
               ev0         = spc_pkg::EV_UPDATE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         steps_ff     <= '0;
         dir_ff       <= 1'b1;
         pulse_ff     <= 1'b0;
         count_per_ff <= '0;
      end else if (in_valid_ff) begin
         position_ff  <= position_in;
         steps_ff     <= steps_in;
         dir_ff       <= dir_in;
         pulse_ff     <= pulse_in;
         count_per_ff <= count_per_in;
      end
   end

   // ---------------- result queue ----------------
   spc_pkg::result_type     entry_in;
   spc_pkg::result_type     queue_ff [DEPTH];
   spc_pkg::result_type     head;
   logic [PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic                    sub_ff;    // second event of the head entry
   logic                    push, pop, rsp_fire;

   assign entry_in.ev0           = ev0;
   assign entry_in.ev1           = ev1;
   assign entry_in.two           = (nev == 2'd2);
   assign entry_in.position      = spc_pkg::VALUE_BITS'(position_in);
   assign entry_in.direction_pin = dir_in ^ invert_dir_ff;
   assign entry_in.step_pulse    = started;
   assign entry_in.moving        = (steps_in != '0) || pulse_in;

   assign head     = queue_ff[rd_ptr_ff];
   assign push     = in_valid_ff && (nev != 2'd0);
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign pop      = rsp_fire && rsp_tlast;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         sub_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
            sub_ff    <= 1'b0;
         end else if (rsp_fire) begin
            sub_ff <= 1'b1;
         end
         count_ff <= count_ff + {{PTR_BITS{1'b0}}, push} - {{PTR_BITS{1'b0}}, pop};
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = sub_ff ? head.ev1 : head.ev0;
   assign rsp_tlast  = sub_ff || !head.two;
   assign rsp_tdata  = {5'b00000, head.moving, head.step_pulse, head.direction_pin,
                        head.position};

   // ---------------- assertions ----------------
   // The period timer runs exactly while a pulse is in flight
   assert property (@(posedge clock) disable iff (reset) pulse_ff == (count_per_ff != '0))
      else $error("period timer and pulse flag disagree");

   // Queue never overfills, counting the reserved input slot
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + {{(PTR_BITS+1){1'b0}}, in_valid_ff}) <= (PTR_BITS + 2)'(DEPTH))
      else $error("result queue overflow");

   // A result that reports a started pulse also reports motion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> rsp_tdata[26])
      else $error("step pulse reported without motion");

   // The second event of a command is only presented for a two-event entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && sub_ff) |-> head.two)
      else $error("second event on a single-event entry");

endmodule
